// ----- sv/merge_sort_engine_defines.svh -----
// Assertion macros shared by the merge sort engine checker.
`ifndef MERGE_SORT_ENGINE_DEFINES_SVH
`define MERGE_SORT_ENGINE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define MSE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Condition that must never hold outside reset.
`define MSE_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("assertion failed");

// Implication that is also checked while reset is applied.
`define MSE_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/mse_pkg.sv -----
// Shared types and constants of the merge sort engine.
`default_nettype none

package mse_pkg;

    localparam int DATA_W            = 32;
    localparam int DEFAULT_MAX_ITEMS = 64;

    typedef logic signed [DATA_W-1:0] t_sample;

    // Which run heads still hold values during a merge step.
    typedef struct packed {
        logic a_live;
        logic b_live;
    } t_merge_ctl;

endpackage

`default_nettype wire

// ----- sv/mse_ram.sv -----
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ----- sv/mse_merge_unit.sv -----
// Compare and select unit: picks the smaller of two run heads.
`default_nettype none

module mse_merge_unit (
    input  wire mse_pkg::t_sample   i_head_a,
    input  wire mse_pkg::t_sample   i_head_b,
    input  wire mse_pkg::t_merge_ctl i_ctl,
    output logic                    o_take_a,
    output mse_pkg::t_sample        o_value
);

    // Ties go to the left run, as in a stable merge.
    always_comb begin
        o_take_a = i_ctl.a_live && (!i_ctl.b_live || (i_head_a <= i_head_b));
        o_value  = o_take_a ? i_head_a : i_head_b;
    end

endmodule

`default_nettype wire

// ----- sv/merge_sort_engine.sv -----
// Top level of the merge sort engine: loader, merge sequencer and output stage.
//
//  Channel  Dir  tdata                    tlast / tuser
//  s_axis   in   [31:0] sample (signed)   tlast = final_item
//  m_axis   out  [31:0] sorted_value      tlast = end_of_run
//
// Loading accepts one item per cycle; tlast closes the set and items past MAX_ITEMS drop.
// Sorting runs ceil(log2 n) bottom-up passes between two RAMs: S_PASS opens each pass,
// S_RUN sets up each run, and each value is read in S_RD and written in S_MRG. Each
// result is read in S_ORD, captured in S_OCAP and held in S_OWAIT until m_axis_tready is high.
// Synchronous active-low reset clears control state only; the RAMs have no reset.
// Input is refused from the final item until the last result is taken.
`default_nettype none

module merge_sort_engine #(
    parameter int MAX_ITEMS = mse_pkg::DEFAULT_MAX_ITEMS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [mse_pkg::DATA_W-1:0]  s_axis_tdata,  // [31:0] sample
    input  wire logic                        s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [mse_pkg::DATA_W-1:0]  m_axis_tdata,  // [31:0] sorted_value
    output logic                             m_axis_tlast
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = CW + 2;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

    // Sequencer states.
    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_PASS  = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_MRG   = 3'd4;
    localparam logic [2:0] S_ORD   = 3'd5;
    localparam logic [2:0] S_OCAP  = 3'd6;
    localparam logic [2:0] S_OWAIT = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;      // values loaded so far
    logic [CW-1:0] r_n, n_n;          // set size being sorted
    logic [CW:0]   r_width, n_width;  // run width of the current pass
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_pa, n_pa;        // left run head, also the output index
    logic [CW-1:0] r_pb, n_pb;        // right run head
    logic [CW-1:0] r_k, n_k;          // merge write index
    logic          r_src, n_src;      // RAM that holds the current data
    logic          r_out_valid, n_out_valid;
    logic          r_out_last, n_out_last;
    mse_pkg::t_sample r_out_data, n_out_data;

    logic             s_fire, m_fire;
    logic             load_we, merge_we;
    logic [AW-1:0]    waddr;
    mse_pkg::t_sample wdata;
    logic [mse_pkg::DATA_W-1:0] ram0_a, ram0_b, ram1_a, ram1_b;
    mse_pkg::t_sample head_a, head_b, pick;
    mse_pkg::t_merge_ctl ctl;
    logic             take_a;
    logic [SW-1:0]    sum_mid, sum_hi, n_ext;

    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;

    assign s_axis_tready = (r_state == S_LOAD);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // Write side: loading fills RAM 0, merging writes the other RAM.
    assign load_we  = s_fire && (r_cnt < MAX_CNT);
    assign merge_we = (r_state == S_MRG);
    assign waddr    = load_we ? r_cnt[AW-1:0] : r_k[AW-1:0];
    assign wdata    = load_we ? mse_pkg::t_sample'(s_axis_tdata) : pick;

    mse_ram #(
        .WIDTH (mse_pkg::DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_ram0 (
        .i_clk     (i_clk),
        .i_we      (load_we || (merge_we && r_src)),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (r_pa[AW-1:0]),
        .i_raddr_b (r_pb[AW-1:0]),
        .o_rdata_a (ram0_a),
        .o_rdata_b (ram0_b)
    );

    mse_ram #(
        .WIDTH (mse_pkg::DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_ram1 (
        .i_clk     (i_clk),
        .i_we      (merge_we && !r_src),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (r_pa[AW-1:0]),
        .i_raddr_b (r_pb[AW-1:0]),
        .o_rdata_a (ram1_a),
        .o_rdata_b (ram1_b)
    );

    assign head_a = r_src ? ram1_a : ram0_a;
    assign head_b = r_src ? ram1_b : ram0_b;

    // A head is live while its pointer is still inside its run.
    assign ctl.a_live = (r_pa < r_mid);
    assign ctl.b_live = (r_pb < r_hi);

    mse_merge_unit u_merge (
        .i_head_a (head_a),
        .i_head_b (head_b),
        .i_ctl    (ctl),
        .o_take_a (take_a),
        .o_value  (pick)
    );

    // Run bounds, clipped to the set size.
    assign n_ext   = SW'(r_n);
    assign sum_mid = SW'(r_lo) + SW'(r_width);
    assign sum_hi  = SW'(r_lo) + (SW'(r_width) << 1);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_width     = r_width;
        n_lo        = r_lo;
        n_mid       = r_mid;
        n_hi        = r_hi;
        n_pa        = r_pa;
        n_pb        = r_pb;
        n_k         = r_k;
        n_src       = r_src;
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;
        n_out_data  = r_out_data;
        case (r_state)
            S_LOAD: begin
                if (s_fire) begin
                    if (load_we) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_n     = load_we ? r_cnt + 1'b1 : r_cnt;
                        n_src   = 1'b0;
                        n_width = (CW+1)'(1);
                        n_state = S_PASS;
                    end
                end
            end
            S_PASS: begin
                if (r_width >= (CW+1)'(r_n)) begin
                    n_pa    = '0;
                    n_state = S_ORD;
                end else begin
                    n_lo    = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_lo >= r_n) begin
                    // Pass done: the merged copy becomes the source.
                    n_width = r_width << 1;
                    n_src   = !r_src;
                    n_state = S_PASS;
                end else begin
                    // A lone left run with no right partner is simply copied.
                    n_mid   = (sum_mid < n_ext) ? sum_mid[CW-1:0] : r_n;
                    n_hi    = (sum_hi < n_ext) ? sum_hi[CW-1:0] : r_n;
                    n_pa    = r_lo;
                    n_pb    = n_mid;
                    n_k     = r_lo;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_MRG;
            end
            S_MRG: begin
                if (take_a) begin
                    n_pa = r_pa + 1'b1;
                end else begin
                    n_pb = r_pb + 1'b1;
                end
                n_k = r_k + 1'b1;
                if (r_k + 1'b1 == r_hi) begin
                    n_lo    = r_hi;
                    n_state = S_RUN;
                end else begin
                    n_state = S_RD;
                end
            end
            S_ORD: begin
                n_state = S_OCAP;
            end
            S_OCAP: begin
                n_out_data  = head_a;
                n_out_last  = (r_pa + 1'b1 == r_n);
                n_out_valid = 1'b1;
                n_state     = S_OWAIT;
            end
            S_OWAIT: begin
                if (m_fire) begin
                    n_out_valid = 1'b0;
                    n_pa        = r_pa + 1'b1;
                    if (r_out_last) begin
                        n_cnt   = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_width    <= n_width;
        r_lo       <= n_lo;
        r_mid      <= n_mid;
        r_hi       <= n_hi;
        r_pa       <= n_pa;
        r_pb       <= n_pb;
        r_k        <= n_k;
        r_src      <= n_src;
        r_out_last <= n_out_last;
        r_out_data <= n_out_data;
    end

endmodule

`default_nettype wire

// ----- sv/mse_checker.sv -----
// Port-level checks of the merge sort engine, bound to the top level.
`default_nettype none
`include "merge_sort_engine_defines.svh"

module mse_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       s_axis_tready,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [mse_pkg::DATA_W-1:0] m_axis_tdata,
    input wire logic                       m_axis_tlast
);

    // A result is waiting on the sink.
    logic out_stall;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    `MSE_ASSERT_IMP(a_out_hold, out_stall, m_axis_tvalid)
    `MSE_ASSERT_IMP(a_out_stable, out_stall, $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `MSE_ASSERT_NEVER(a_load_xor_emit, s_axis_tready && m_axis_tvalid)
    `MSE_ASSERT_IMP(a_last_reloads, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid && s_axis_tready)
    `MSE_ASSERT_RST(a_reset_idle, !i_rst_n, s_axis_tready && !m_axis_tvalid)

endmodule

bind merge_sort_engine mse_checker u_mse_checker (.*);

`default_nettype wire
